### design/assert_macros.svh
// Assertion macros shared by the display mode sequencer RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, during reset too.
`define ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/lmts_pkg.sv
// Package for the display mode sequencer: payload structs, state struct,
// opcodes, mode codes, timing constants and the scroll penalty table. No dependencies.
package lmts_pkg;

    // Request opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CTRL = 2'd1;
    localparam logic [1:0] OP_STAT = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LINE_COMPARE  = 1'b0;
    localparam logic CFG_FINE_SCROLL_X = 1'b1;

    // Display modes
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lmts_mode_t;

    // Tick counts
    localparam logic [6:0] HBLANK_TICKS   = 7'd50;
    localparam logic [6:0] VBLANK_TICKS   = 7'd114;
    localparam logic [6:0] OAM_TICKS      = 7'd21;
    localparam logic [6:0] XFER_TICKS     = 7'd43;
    localparam logic [6:0] OFF_COUNTDOWN  = 7'd115;
    localparam logic [6:0] RESET_COUNTDOWN = 7'd80;

    // Line limits
    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE         = 8'd153;

    // Status bit positions within the 5-bit status field
    localparam int ST_COIN     = 0;
    localparam int ST_HBL_EN   = 1;
    localparam int ST_VBL_EN   = 2;
    localparam int ST_OAM_EN   = 3;
    localparam int ST_COIN_EN  = 4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] write_data;
    } lmts_in_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic [7:0] status_read;
        logic       vblank_irq;
        logic       stat_irq;
        logic       render_line;
        logic       display_on;
    } lmts_out_t;

    typedef struct packed {
        logic       enabled;
        lmts_mode_t mode;
        logic [7:0] line;
        logic [6:0] countdown;
        logic [4:0] status;
    } lmts_state_t;

    // Transfer penalty in ticks for the fine horizontal scroll
    function automatic logic [1:0] scroll_penalty(input logic [2:0] fine);
        logic [1:0] pen;
        case (fine)
            3'd0:    pen = 2'd0;
            3'd1:    pen = 2'd1;
            3'd2:    pen = 2'd1;
            3'd3:    pen = 2'd1;
            3'd4:    pen = 2'd1;
            default: pen = 2'd2;
        endcase
        return pen;
    endfunction

endpackage

### design/lmts_step.sv
// Next-state and result logic for one request of the display mode sequencer.
// Purely combinational; depends on lmts_pkg.
module lmts_step
    import lmts_pkg::*;
(
    input  lmts_state_t state,
    input  logic [7:0]  line_compare,
    input  logic [2:0]  fine_scroll_x,
    input  lmts_in_t    req,
    output lmts_state_t state_next,
    output lmts_out_t   result
);

    logic [6:0] dec;
    logic [7:0] line_inc;
    logic [6:0] pen;
    logic       coin_chk;
    logic       coin;
    logic       vbl;
    logic       stat;
    logic       render;

    assign dec      = state.countdown - 7'd1;
    assign line_inc = state.line + 8'd1;
    assign pen      = {5'd0, scroll_penalty(fine_scroll_x)};

    // Mode / line / countdown update
    always_comb
    begin
        state_next = state;
        coin_chk   = 1'b0;
        coin       = 1'b0;
        vbl        = 1'b0;
        stat       = 1'b0;
        render     = 1'b0;
        case (req.opcode)
            OP_TICK:
            begin
                if (state.enabled)
                begin
                    state_next.countdown = dec;
                    // early hblank interrupt, one tick before transfer ends
                    if (dec == 7'd1 && state.mode == MODE_XFER && state.status[ST_HBL_EN])
                        stat = 1'b1;
                    if (dec == 7'd0)
                    begin
                        case (state.mode)
                            MODE_HBLANK:
                            begin
                                coin_chk        = 1'b1;
                                state_next.line = line_inc;
                                if (line_inc < FIRST_VBLANK_LINE)
                                begin
                                    state_next.mode      = MODE_OAM;
                                    state_next.countdown = OAM_TICKS;
                                    if (state.status[ST_OAM_EN])
                                        stat = 1'b1;
                                end
                                else
                                begin
                                    state_next.mode      = MODE_VBLANK;
                                    state_next.countdown = VBLANK_TICKS;
                                    vbl                  = 1'b1;
                                    if (state.status[ST_VBL_EN] || state.status[ST_OAM_EN])
                                        stat = 1'b1;
                                end
                            end
                            MODE_VBLANK:
                            begin
                                coin_chk = 1'b1;
                                if (line_inc > LAST_LINE)
                                begin
                                    state_next.line      = 8'd0;
                                    state_next.mode      = MODE_OAM;
                                    state_next.countdown = OAM_TICKS;
                                    if (state.status[ST_OAM_EN])
                                        stat = 1'b1;
                                end
                                else
                                begin
                                    state_next.line      = line_inc;
                                    state_next.countdown = VBLANK_TICKS;
                                end
                            end
                            MODE_OAM:
                            begin
                                state_next.mode      = MODE_XFER;
                                state_next.countdown = XFER_TICKS + pen;
                            end
                            MODE_XFER:
                            begin
                                render               = 1'b1;
                                state_next.mode      = MODE_HBLANK;
                                state_next.countdown = HBLANK_TICKS - pen;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_CTRL:
            begin
                // display off: park at line 0 in hblank
                if (!req.write_data[7])
                begin
                    state_next.line      = 8'd0;
                    state_next.countdown = OFF_COUNTDOWN;
                    state_next.mode      = MODE_HBLANK;
                end
                state_next.enabled = req.write_data[7];
            end
            OP_STAT:
            begin
                state_next.status = req.write_data[6:2];
            end
            default: ;
        endcase

        // Coincidence on line change
        if (coin_chk)
        begin
            coin                       = (state_next.line == line_compare);
            state_next.status[ST_COIN] = coin;
            if (coin && state.status[ST_COIN_EN])
                stat = 1'b1;
        end
    end

    // Result item
    always_comb
    begin
        result.mode        = state_next.mode;
        result.line        = state_next.line;
        result.status_read = {1'b1, state_next.status, state_next.mode};
        result.vblank_irq  = vbl;
        result.stat_irq    = stat;
        result.render_line = render;
        result.display_on  = state_next.enabled;
    end

endmodule

### design/lmts_out_reg.sv
// Result register with valid/ready handshake for the display mode sequencer.
// Takes a new result whenever empty or being drained; depends on lmts_pkg.
module lmts_out_reg
    import lmts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  lmts_out_t load_item,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output lmts_out_t out_item
);

    logic      valid_reg;
    logic      valid_next;
    lmts_out_t item_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= load_item;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### design/lcd_mode_timing_sequencer.sv
// Top level of the display mode sequencer: config and state registers,
// step logic and result register. Depends on lmts_pkg, lmts_step, lmts_out_reg.
//
//  channel | signals                          | payload
//  in      | in_valid / in_ready              | in_item (lmts_in_t)
//  out     | out_valid / out_ready            | out_item (lmts_out_t)
//  cfg     | cfg_write, cfg_index, cfg_data   | line_compare, fine_scroll_x
//
// One request per cycle while in_ready is high; each request's result is captured in the result register on acceptance.
// The state update and result are one combinational pass from the state registers.
// in_ready is high whenever the result register is empty or being drained.
// Reset: display on, hblank, line 0, countdown 80, status bits and config cleared.
`include "assert_macros.svh"

module lcd_mode_timing_sequencer
    import lmts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lmts_in_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output lmts_out_t  out_item,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    lmts_state_t state_reg;
    lmts_state_t state_next;
    lmts_out_t   result;
    logic [7:0]  line_compare_reg;
    logic [2:0]  fine_scroll_reg;
    logic        accept;

    assign accept = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_compare_reg <= 8'd0;
            fine_scroll_reg  <= 3'd0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_LINE_COMPARE)
                line_compare_reg <= cfg_data;
            else if (cfg_index == CFG_FINE_SCROLL_X)
                fine_scroll_reg <= cfg_data[2:0];
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.enabled   <= 1'b1;
            state_reg.mode      <= MODE_HBLANK;
            state_reg.line      <= 8'd0;
            state_reg.countdown <= RESET_COUNTDOWN;
            state_reg.status    <= 5'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    lmts_step u_step (
        .state         (state_reg),
        .line_compare  (line_compare_reg),
        .fine_scroll_x (fine_scroll_reg),
        .req           (in_item),
        .state_next    (state_next),
        .result        (result)
    );

    lmts_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_item (result),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Checks
    `ASSERT_RST(a_accept_fills, accept |=> out_valid, "accepted request produced no result")
    `ASSERT_RST(a_no_overrun, (out_valid && !out_ready) |-> !in_ready, "request taken over a stalled result")
    `ASSERT_RST(a_vbl_entry, (out_valid && out_item.vblank_irq) |-> (out_item.line == FIRST_VBLANK_LINE && out_item.mode == MODE_VBLANK), "vblank irq off first vblank line")
    `ASSERT_RST(a_line_range, state_reg.line <= LAST_LINE, "line counter beyond last line")

endmodule
